// File: sv/bis_pkg.sv
// ----------------------------------------------------------------------------
// bis_pkg: shared constants and types for the binary insertion sorter
// List depth, derived widths and the write-port bundle for the list RAM.
// ----------------------------------------------------------------------------
`default_nettype none

package bis_pkg;

  localparam int unsigned DEPTH  = 64;                 // 2 .. 64
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned DATA_W = 32;

  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(DEPTH);

  typedef struct packed {
    logic                     we;
    logic [ADDR_W-1:0]        addr;
    logic signed [DATA_W-1:0] data;
  } ram_wr_t;

endpackage

`default_nettype wire

// File: sv/binary_insertion_sorter.sv
// ----------------------------------------------------------------------------
// binary_insertion_sorter: streaming insertion sort over a RAM-held list
// Keeps an ascending list of signed 32-bit words and dumps it on the last word.
// ----------------------------------------------------------------------------
// Each accepted input word is placed into an ascending list held in a RAM of
// DEPTH entries (bis_pkg). The insertion point comes from a binary search;
// each probe issues the RAM address in S_PROBE, then compares on the
// registered read data in S_CMP. A probe that hits an equal value places the
// new word right after it. Entries from the insertion point up then move one
// slot higher, one entry per cycle through the RAM's read and write ports,
// and the new word is written last. A word dropped on a full list goes
// through no search and no shift. in_ready_o is high only between words.
// When last_item_i is set, the whole list is read back in ascending order;
// each output word is read from the RAM in S_OUT_RD, which waits until the
// output register is free, then loaded into the output register in S_OUT_LD.
// end_of_set_o marks the final one, and the list is emptied. A word that
// arrives while the list is full is dropped; the sticky overflowed_o flag
// then rides on every word of that set's output.
// The RAM needs no clearing: only entries below the fill count are read.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_insertion_sorter (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,

  input  wire logic                                 in_valid_i,
  output logic                                      in_ready_o,
  input  wire logic signed [bis_pkg::DATA_W-1:0]    value_i,
  input  wire logic                                 last_item_i,

  output logic                                      out_valid_o,
  input  wire logic                                 out_ready_i,
  output logic signed      [bis_pkg::DATA_W-1:0]    sorted_value_o,
  output logic                                      end_of_set_o,
  output logic                                      overflowed_o
);

  typedef enum logic [2:0] {
    S_IDLE,     // waiting for an input word
    S_PROBE,    // issue RAM read at the search midpoint
    S_CMP,      // compare probe with the new word, narrow the range
    S_SHIFT,    // move entries up, one per cycle
    S_INSERT,   // write the new word at its slot
    S_OUT_RD,   // read next list entry for output
    S_OUT_LD    // load output register
  } state_e;

  state_e state_q;

  // List bookkeeping
  logic [bis_pkg::CNT_W-1:0]          fill_q;
  logic                               drop_q;

  // Word under insertion
  logic signed [bis_pkg::DATA_W-1:0]  val_q;
  logic                               last_q;

  // Search window [lo, hi) and result
  logic [bis_pkg::CNT_W-1:0]          lo_q;
  logic [bis_pkg::CNT_W-1:0]          hi_q;
  logic [bis_pkg::CNT_W-1:0]          mid_q;
  logic [bis_pkg::CNT_W-1:0]          pos_q;

  // Shift sweep: k_q is the next slot to fill from slot k_q-1
  logic [bis_pkg::CNT_W-1:0]          k_q;
  logic                               wr_pend_q;
  logic [bis_pkg::ADDR_W-1:0]         wr_addr_q;

  // Output sweep
  logic [bis_pkg::CNT_W-1:0]          idx_q;
  logic signed [bis_pkg::DATA_W-1:0]  out_val_q;
  logic                               out_valid_q;
  logic                               out_end_q;
  logic                               out_ovf_q;

  // RAM
  bis_pkg::ram_wr_t                   ram_wr;
  logic [bis_pkg::ADDR_W-1:0]         ram_raddr;
  logic signed [bis_pkg::DATA_W-1:0]  ram_rdata;

  logic [bis_pkg::CNT_W-1:0]          mid;
  logic [bis_pkg::CNT_W-1:0]          k_m1;
  logic                               in_fire;
  logic                               out_fire;
  logic                               out_free;
  logic                               out_last;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i & in_ready_o;
  assign out_fire   = out_valid_q & out_ready_i;
  assign out_free   = ~out_valid_q | out_ready_i;
  assign out_last   = ((idx_q + bis_pkg::CNT_ONE) == fill_q);

  // Midpoint with inclusive upper bound hi-1; only used while lo < hi
  assign mid  = lo_q + ((hi_q - bis_pkg::CNT_ONE - lo_q) >> 1);
  assign k_m1 = k_q - bis_pkg::CNT_ONE;

  always_comb begin
    ram_wr.we   = 1'b0;
    ram_wr.addr = wr_addr_q;
    ram_wr.data = ram_rdata;
    ram_raddr   = '0;
    case (state_q)
      S_PROBE: ram_raddr = mid[bis_pkg::ADDR_W-1:0];
      S_SHIFT: begin
        ram_wr.we = wr_pend_q;
        ram_raddr = k_m1[bis_pkg::ADDR_W-1:0];
      end
      S_INSERT: begin
        ram_wr.we   = 1'b1;
        ram_wr.addr = pos_q[bis_pkg::ADDR_W-1:0];
        ram_wr.data = val_q;
      end
      S_OUT_RD: ram_raddr = idx_q[bis_pkg::ADDR_W-1:0];
      default:  ram_raddr = '0;
    endcase
  end

  bis_ram u_ram (
    .clk_i   (clk_i),
    .wr_i    (ram_wr),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      val_q  <= value_i;
      last_q <= last_item_i;
    end
    if (state_q == S_OUT_LD) begin
      out_val_q <= ram_rdata;
      out_end_q <= out_last;
      out_ovf_q <= drop_q;
    end
  end

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= '0;
      drop_q      <= 1'b0;
      lo_q        <= '0;
      hi_q        <= '0;
      mid_q       <= '0;
      pos_q       <= '0;
      k_q         <= '0;
      wr_pend_q   <= 1'b0;
      wr_addr_q   <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_fire) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            idx_q <= '0;
            if (fill_q < bis_pkg::CNT_MAX) begin
              lo_q    <= '0;
              hi_q    <= fill_q;
              state_q <= S_PROBE;
            end else begin
              // list full: drop the word
              drop_q  <= 1'b1;
              state_q <= last_item_i ? S_OUT_RD : S_IDLE;
            end
          end
        end
        S_PROBE: begin
          if (lo_q < hi_q) begin
            mid_q   <= mid;
            state_q <= S_CMP;
          end else begin
            pos_q     <= lo_q;
            k_q       <= fill_q;
            wr_pend_q <= 1'b0;
            state_q   <= S_SHIFT;
          end
        end
        S_CMP: begin
          if (ram_rdata == val_q) begin
            // equal value: new word goes right after the probe
            pos_q     <= mid_q + bis_pkg::CNT_ONE;
            k_q       <= fill_q;
            wr_pend_q <= 1'b0;
            state_q   <= S_SHIFT;
          end else begin
            if (ram_rdata < val_q) begin
              lo_q <= mid_q + bis_pkg::CNT_ONE;
            end else begin
              hi_q <= mid_q;
            end
            state_q <= S_PROBE;
          end
        end
        S_SHIFT: begin
          // read k-1 now, write it to k next cycle
          if (k_q > pos_q) begin
            wr_pend_q <= 1'b1;
            wr_addr_q <= k_q[bis_pkg::ADDR_W-1:0];
            k_q       <= k_m1;
          end else begin
            wr_pend_q <= 1'b0;
            state_q   <= S_INSERT;
          end
        end
        S_INSERT: begin
          fill_q  <= fill_q + bis_pkg::CNT_ONE;
          state_q <= last_q ? S_OUT_RD : S_IDLE;
        end
        S_OUT_RD: begin
          // hold the read until the output register frees up
          if (out_free) begin
            state_q <= S_OUT_LD;
          end
        end
        S_OUT_LD: begin
          out_valid_q <= 1'b1;
          if (out_last) begin
            fill_q  <= '0;
            drop_q  <= 1'b0;
            state_q <= S_IDLE;
          end else begin
            idx_q   <= idx_q + bis_pkg::CNT_ONE;
            state_q <= S_OUT_RD;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign sorted_value_o = out_val_q;
  assign end_of_set_o   = out_end_q;
  assign overflowed_o   = out_ovf_q;

endmodule

`default_nettype wire

// File: sv/bis_ram.sv
// ----------------------------------------------------------------------------
// bis_ram: list storage
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module bis_ram (
  input  wire logic                                      clk_i,
  input  wire bis_pkg::ram_wr_t                          wr_i,
  input  wire logic        [bis_pkg::ADDR_W-1:0]         raddr_i,
  output logic signed      [bis_pkg::DATA_W-1:0]         rdata_o
);

  logic signed [bis_pkg::DATA_W-1:0] mem [bis_pkg::DEPTH];
  logic signed [bis_pkg::DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire
